@@ design/dhti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_pkg
// Shared types and constants of the double-hashing insert table.
// ----------------------------------------------------------------------------
package dhti_pkg;

	localparam int DEPTH      = 1024;
	localparam int ADDR_W     = 10;
	localparam int SIZE_W     = 11;
	localparam int KEY_W      = 64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic REG_STEP_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_INS,
		RES_FULL,
		RES_READ,
		RES_ZERO
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      mul_step;
		logic      div_load;
		logic      div_step;
		logic      div_both;
		logic      mid_load;
		logic      probe_init;
		logic      probe_adv;
		logic      rd_idx;
		logic      ins_write;
		logic      clr_init;
		logic      clr_step;
		res_kind_t emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       slot_busy;
		logic       last_probe;
		logic       clr_last;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ design/dhti_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_ctrl
// Sequencer: hashing, reductions, probe walk, slot read and table clear.
// ----------------------------------------------------------------------------
module dhti_ctrl import dhti_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] op,
	input  wire dp_stat_t stat,
	output logic          busy,
	output dp_cmd_t       cmd
);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_MUL   = 13'b0000000000100,
		S_PREP  = 13'b0000000001000,
		S_DIV1  = 13'b0000000010000,
		S_MID   = 13'b0000000100000,
		S_DIV2  = 13'b0000001000000,
		S_PSET  = 13'b0000010000000,
		S_PRD   = 13'b0000100000000,
		S_PCHK  = 13'b0001000000000,
		S_RD    = 13'b0010000000000,
		S_RDOUT = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       pend_q, pend_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.emit = RES_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					if (pend_q) cmd.emit = RES_ZERO;
					pend_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cnt_d = '0;
					case (op)
						OP_INSERT: state_d = S_MUL;
						OP_READ:   state_d = S_RD;
						OP_CLEAR: begin
							cmd.clr_init = 1'b1;
							pend_d  = 1'b1;
							state_d = S_CLEAR;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd7) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.div_load = 1'b1;
				cnt_d   = '0;
				state_d = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				cmd.div_both = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(KEY_W - 1)) state_d = S_MID;
			end
			S_MID: begin
				cmd.mid_load = 1'b1;
				cnt_d   = '0;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(SIZE_W - 1)) state_d = S_PSET;
			end
			S_PSET: begin
				cmd.probe_init = 1'b1;
				state_d = S_PRD;
			end
			S_PRD: begin
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (!stat.slot_busy) begin
					cmd.ins_write = 1'b1;
					cmd.emit = RES_INS;
					state_d  = S_IDLE;
				end else if (stat.last_probe) begin
					cmd.emit = RES_FULL;
					state_d  = S_IDLE;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d = S_PRD;
				end
			end
			S_RD: begin
				cmd.rd_idx = 1'b1;
				state_d = S_RDOUT;
			end
			S_RDOUT: begin
				cmd.emit = RES_READ;
				state_d  = S_IDLE;
			end
			S_FIN: begin
				cmd.emit = RES_ZERO;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ design/dhti_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_dp
// Datapath: registers, byte multiplier, remainder units, slot memories.
// ----------------------------------------------------------------------------
module dhti_dp import dhti_pkg::*; #(
	parameter int TAG_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	input  wire logic [1:0]           op,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [TAG_WIDTH-1:0] record_tag,
	input  wire logic [ADDR_W-1:0]    slot_index,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	output logic                      done,
	output logic [ADDR_W-1:0]         slot,
	output logic [ADDR_W-1:0]         home_hash,
	output logic [SIZE_W-1:0]         comparisons,
	output logic [KEY_W-1:0]          stored_key,
	output logic [TAG_WIDTH-1:0]      stored_tag,
	output logic                      occupied,
	output logic                      table_full
);

	localparam int DW = ADDR_W + TAG_WIDTH + KEY_W;

	logic [SIZE_W-1:0]    tsize_q, slimit_q, n_eff, lim_eff;
	logic [1:0]           op_q;
	logic [KEY_W-1:0]     key_q, mkey_q, prod_q, shift_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [ADDR_W-1:0]    idx_q, home_q, step_q, pos_q;
	logic [SIZE_W-1:0]    ra_q, rb_q, cmp_q, cmp_inc, pos_sum, clr_q;
	logic [7:0]           mbyte;

	logic                 vmem [DEPTH];
	logic [DW-1:0]        dmem [DEPTH];
	logic                 vrd_q;
	logic [DW-1:0]        drd_q;
	logic [ADDR_W-1:0]    vaddr, waddr;
	logic                 vwe, vwd;

	function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
			input logic b, input logic [SIZE_W-1:0] d);
		logic [SIZE_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) t = t - {1'b0, d};
		return t[SIZE_W-1:0];
	endfunction

	// Out-of-range register values are pulled into the usable range here.
	always_comb begin
		if (tsize_q == '0) n_eff = SIZE_W'(1);
		else if (tsize_q > SIZE_W'(DEPTH)) n_eff = SIZE_W'(DEPTH);
		else n_eff = tsize_q;
		lim_eff = (slimit_q == '0) ? SIZE_W'(1) : slimit_q;
	end

	assign mbyte   = (mkey_q[7:0] == 8'd0) ? 8'd1 : mkey_q[7:0];
	assign cmp_inc = cmp_q + SIZE_W'(1);
	assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q  <= SIZE_W'(1021);
			slimit_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_TABLE_SIZE) tsize_q <= cfg_data;
			if (cfg_index == REG_STEP_LIMIT) slimit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			key_q  <= key;
			mkey_q <= key;
			tag_q  <= record_tag;
			idx_q  <= slot_index;
			prod_q <= KEY_W'(1);
		end
		if (cmd.mul_step) begin
			prod_q <= prod_q * {{(KEY_W-8){1'b0}}, mbyte};
			mkey_q <= mkey_q >> 8;
		end
		if (cmd.div_load) begin
			shift_q <= prod_q;
			ra_q    <= '0;
			rb_q    <= '0;
		end
		if (cmd.div_step) begin
			shift_q <= shift_q << 1;
			ra_q    <= rem_step(ra_q, shift_q[KEY_W-1], n_eff);
			if (cmd.div_both) rb_q <= rem_step(rb_q, shift_q[KEY_W-1], lim_eff);
		end
		// The raw step sits in the top bits so its reduction needs only SIZE_W steps.
		if (cmd.mid_load) begin
			home_q  <= ra_q[ADDR_W-1:0];
			shift_q <= {lim_eff - rb_q, {(KEY_W-SIZE_W){1'b0}}};
			ra_q    <= '0;
		end
		if (cmd.probe_init) begin
			step_q <= ra_q[ADDR_W-1:0];
			pos_q  <= home_q;
			cmp_q  <= '0;
		end
		if (cmd.probe_adv) begin
			cmp_q <= cmp_inc;
			pos_q <= (pos_sum >= n_eff) ? ADDR_W'(pos_sum - n_eff) : pos_sum[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_init) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= cmd.clr_step ? clr_q + SIZE_W'(1) : clr_q;
	end

	assign stat.op         = op_q;
	assign stat.slot_busy  = vrd_q;
	assign stat.last_probe = (cmp_inc == n_eff);
	assign stat.clr_last   = (clr_q == SIZE_W'(DEPTH - 1));

	assign vaddr = cmd.rd_idx ? idx_q : pos_q;
	assign waddr = cmd.clr_step ? clr_q[ADDR_W-1:0] : pos_q;
	assign vwe   = cmd.clr_step | cmd.ins_write;
	assign vwd   = cmd.ins_write;

	always_ff @(posedge clk) begin
		if (vwe) vmem[waddr] <= vwd;
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) dmem[pos_q] <= {home_q, tag_q, key_q};
		drd_q <= dmem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= (cmd.emit != RES_NONE);
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != RES_NONE) begin
			slot        <= '0;
			home_hash   <= '0;
			comparisons <= '0;
			stored_key  <= '0;
			stored_tag  <= '0;
			occupied    <= 1'b0;
			table_full  <= 1'b0;
			case (cmd.emit)
				RES_INS: begin
					slot        <= pos_q;
					home_hash   <= home_q;
					comparisons <= cmp_inc;
				end
				RES_FULL: begin
					home_hash   <= home_q;
					comparisons <= cmp_inc;
					table_full  <= 1'b1;
				end
				RES_READ: begin
					slot <= idx_q;
					if (vrd_q) begin
						home_hash  <= drd_q[DW-1 -: ADDR_W];
						stored_tag <= drd_q[KEY_W +: TAG_WIDTH];
						stored_key <= drd_q[KEY_W-1:0];
						occupied   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/double_hash_table_insert_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_insert_top
// Open-addressing hash table with double hashing: insert, slot read, clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result, shown for one cycle with done high, and it must be taken then.
// An insert runs a byte multiplication over the eight key bytes, a bit-serial
// remainder of the product by table_size and step_limit, a reduction of the
// step by table_size, then a registered read of the occupancy memory and a
// check per probe. A clear is a one-slot-per-cycle sweep of the occupancy
// memory. The same sweep runs after reset, with busy high; configuration
// writes are taken at any time.
module double_hash_table_insert_top import dhti_pkg::*; #(
	parameter int TAG_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           op,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [TAG_WIDTH-1:0] record_tag,
	input  wire logic [ADDR_W-1:0]    slot_index,
	output logic                      done,
	output logic [ADDR_W-1:0]         slot,
	output logic [ADDR_W-1:0]         home_hash,
	output logic [SIZE_W-1:0]         comparisons,
	output logic [KEY_W-1:0]          stored_key,
	output logic [TAG_WIDTH-1:0]      stored_tag,
	output logic                      occupied,
	output logic                      table_full
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dhti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	dhti_dp #(.TAG_WIDTH(TAG_WIDTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.key         (key),
		.record_tag  (record_tag),
		.slot_index  (slot_index),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.slot        (slot),
		.home_hash   (home_hash),
		.comparisons (comparisons),
		.stored_key  (stored_key),
		.stored_tag  (stored_tag),
		.occupied    (occupied),
		.table_full  (table_full)
	);

`ifndef SYNTH
	// A result only follows a cycle of work.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without prior work");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> (!occupied && slot == '0))
		else $error("full insert reported slot contents");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-hashing insert table: a queue-fed driver
// sends inserts, slot reads, clears and unused ops between register updates, and a
// monitor compares every result with the table predicted inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import dhti_pkg::*;

	typedef struct {
		bit               is_cfg;
		logic             reg_sel;
		logic [SIZE_W-1:0] reg_val;
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [15:0]      tag;
		logic [ADDR_W-1:0] sidx;
	} pend_t;

	typedef struct packed {
		logic [ADDR_W-1:0] slot;
		logic [ADDR_W-1:0] home;
		logic [SIZE_W-1:0] cmp;
		logic [KEY_W-1:0]  skey;
		logic [15:0]       stag;
		logic              occ;
		logic              full;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic [1:0] op = '0;
	logic [KEY_W-1:0] key = '0;
	logic [15:0] record_tag = '0;
	logic [ADDR_W-1:0] slot_index = '0;
	logic busy, done, occupied, table_full;
	logic [ADDR_W-1:0] slot, home_hash;
	logic [SIZE_W-1:0] comparisons;
	logic [KEY_W-1:0] stored_key;
	logic [15:0] stored_tag;

	pend_t pending[$];
	res_t results_due[$];
	pend_t cur;
	int n_taken = 0;
	bit failed = 1'b0;

	// Table as the bench expects it.
	logic [SIZE_W-1:0] tsize = 11'd1021;
	logic [SIZE_W-1:0] slim = 11'd1;
	bit               mdl_valid[DEPTH];
	logic [KEY_W-1:0] mdl_key[DEPTH];
	logic [15:0]      mdl_tag[DEPTH];
	logic [ADDR_W-1:0] mdl_home[DEPTH];

	double_hash_table_insert_top #(.TAG_WIDTH(16)) uut (.*);

	always #4 clk = ~clk;

	function automatic res_t table_result(pend_t it);
		res_t r;
		longint unsigned prod, n, lim, home, stp, pos, cnt;
		bit hit;
		r = '0;
		case (it.op)
			OP_INSERT: begin
				n = (tsize == 0) ? 1 : ((tsize > DEPTH) ? DEPTH : tsize);
				lim = (slim == 0) ? 1 : slim;
				prod = 1;
				for (int i = 0; i < 8; i++)
					if (it.key[8*i +: 8] != 0)
						prod = prod * it.key[8*i +: 8];
				home = prod % n;
				stp = (lim - prod % lim) % n;
				pos = home;
				cnt = 0;
				hit = 0;
				while (cnt < n) begin
					cnt++;
					if (!mdl_valid[pos]) begin
						hit = 1;
						break;
					end
					pos += stp;
					if (pos >= n)
						pos -= n;
				end
				r.home = home;
				r.cmp = cnt;
				if (hit) begin
					mdl_valid[pos] = 1;
					mdl_key[pos] = it.key;
					mdl_tag[pos] = it.tag;
					mdl_home[pos] = home;
					r.slot = pos;
				end else begin
					r.full = 1;
				end
			end
			OP_READ: begin
				r.slot = it.sidx;
				if (mdl_valid[it.sidx]) begin
					r.home = mdl_home[it.sidx];
					r.skey = mdl_key[it.sidx];
					r.stag = mdl_tag[it.sidx];
					r.occ = 1;
				end
			end
			OP_CLEAR: begin
				foreach (mdl_valid[i])
					mdl_valid[i] = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: one item or register write at a time from the pending queue.
	always @(posedge clk) begin
		logic nxt_start, nxt_we;
		int idle_pct;
		nxt_start = start;
		nxt_we = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				results_due = {results_due, table_result(cur)};
				n_taken++;
				nxt_start = 1'b0;
			end
			idle_pct = (n_taken < 600) ? 27 : ((n_taken < 1200) ? 57 : 0);
			if (!nxt_start && pending.size() > 0) begin
				if (pending[0].is_cfg) begin
					// Registers change only with the table at rest.
					if (results_due.size() == 0 && !busy) begin
						cur = pending.pop_front();
						if (cur.reg_sel == REG_TABLE_SIZE)
							tsize = cur.reg_val;
						else
							slim = cur.reg_val;
						nxt_we = 1'b1;
						cfg_index <= cur.reg_sel;
						cfg_data <= cur.reg_val;
					end
				end else if ($urandom_range(99) >= idle_pct) begin
					cur = pending.pop_front();
					nxt_start = 1'b1;
					op <= cur.op;
					key <= cur.key;
					record_tag <= cur.tag;
					slot_index <= cur.sidx;
				end
			end
		end
		start <= nxt_start;
		cfg_we <= nxt_we;
	end

	function automatic void check_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			failed = 1'b1;
		end
	endfunction

	// Monitor: every done strobe carries the result of the oldest item.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				$display("%0t unexpected result: expected none actual slot %h", $time, slot);
				failed = 1'b1;
			end else begin
				e = results_due.pop_front();
				check_field("slot", e.slot, slot);
				check_field("home_hash", e.home, home_hash);
				check_field("comparisons", e.cmp, comparisons);
				check_field("stored_key", e.skey, stored_key);
				check_field("stored_tag", e.stag, stored_tag);
				check_field("occupied", e.occ, occupied);
				check_field("table_full", e.full, table_full);
			end
		end
	end

	task automatic add_cfg(logic sel, logic [SIZE_W-1:0] val);
		pend_t p;
		p = '{default: '0};
		p.is_cfg = 1;
		p.reg_sel = sel;
		p.reg_val = val;
		pending = {pending, p};
	endtask

	task automatic add_op(logic [1:0] o, logic [KEY_W-1:0] k, logic [15:0] t,
			logic [ADDR_W-1:0] s);
		pend_t p;
		p = '{default: '0};
		p.op = o;
		p.key = k;
		p.tag = t;
		p.sidx = s;
		pending = {pending, p};
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		int mode;
		mode = $urandom_range(2);
		k = {$urandom, $urandom};
		// Zero bytes are skipped in the product, and tiny bytes collide often.
		for (int i = 0; i < 8; i++) begin
			if (mode == 1 && $urandom_range(1))
				k[8*i +: 8] = 8'h00;
			if (mode == 2)
				k[8*i +: 8] = $urandom_range(3);
		end
		return k;
	endfunction

	initial begin
		int sizes[] = '{2, 3, 5, 7, 11, 13, 17, 31};
		int mids[] = '{61, 127, 251};
		int bigs[] = '{0, 1021, 1024, 2047};
		int sz, len, pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default registers, extremes of keys and slots, all ops.
		add_op(OP_INSERT, 64'h0, 16'h0000, 10'h000);
		add_op(OP_INSERT, {KEY_W{1'b1}}, 16'hFFFF, 10'h3FF);
		add_op(OP_INSERT, {KEY_W{1'b1}}, 16'h5A5A, 10'h000);
		add_op(OP_READ, 64'h0, 16'h0, 10'd1);
		add_op(OP_READ, {KEY_W{1'b1}}, 16'hFFFF, 10'h3FF);
		add_op(2'd3, {KEY_W{1'b1}}, 16'hFFFF, 10'h3FF);
		add_op(OP_CLEAR, 64'h0, 16'h0, 10'h0);
		add_op(OP_READ, 64'h0, 16'h0, 10'd1);
		// Registers of zero act as one: a one-slot table fills at once.
		add_cfg(REG_TABLE_SIZE, 11'd0);
		add_cfg(REG_STEP_LIMIT, 11'd0);
		add_op(OP_INSERT, 64'h0102_0304_0506_0708, 16'h1234, 10'h0);
		add_op(OP_INSERT, 64'h0000_0000_0000_0002, 16'h4321, 10'h0);
		add_op(OP_READ, 64'h0, 16'h0, 10'h0);
		// An oversized table size acts as the full depth; the step limit is used as written.
		add_cfg(REG_TABLE_SIZE, 11'h7FF);
		add_cfg(REG_STEP_LIMIT, 11'h7FF);
		add_op(OP_INSERT, 64'hFF00_FF00_FF00_FF00, 16'hBEEF, 10'h0);
		add_op(OP_READ, 64'h0, 16'h0, 10'h3FF);
		// Step equal to the table size reduces to zero and never moves.
		add_cfg(REG_TABLE_SIZE, 11'd4);
		add_cfg(REG_STEP_LIMIT, 11'd4);
		add_op(OP_CLEAR, 64'h0, 16'h0, 10'h0);
		repeat (5)
			add_op(OP_INSERT, 64'h4, $urandom, 10'h0);
		for (int i = 0; i < 4; i++)
			add_op(OP_READ, 64'h0, 16'h0, i);

		// Random segments: both registers, mostly a clear, then a burst of inserts,
		// reads, rare clears and unused ops that usually runs the table full.
		while (pending.size() + n_taken < 1700) begin
			pick = $urandom_range(99);
			if (pick < 80)
				sz = sizes[$urandom_range(sizes.size() - 1)];
			else if (pick < 92)
				sz = mids[$urandom_range(mids.size() - 1)];
			else
				sz = bigs[$urandom_range(bigs.size() - 1)];
			add_cfg(REG_TABLE_SIZE, sz);
			add_cfg(REG_STEP_LIMIT, $urandom_range(1) ? $urandom_range(2047)
				: $urandom_range((sz > 2045) ? 2047 : sz + 2));
			if ($urandom_range(9) != 0)
				add_op(OP_CLEAR, rand_key(), $urandom, $urandom);
			len = (sz > 300 || sz == 0) ? 20 : ((2 * sz + 6 > 60) ? 60 : 2 * sz + 6);
			repeat (len) begin
				pick = $urandom_range(99);
				if (pick < 60)
					add_op(OP_INSERT, rand_key(), $urandom, $urandom);
				else if (pick < 93)
					add_op(OP_READ, rand_key(), $urandom,
						$urandom_range(3) ? $urandom_range((sz > 1) ? sz - 1 : 0)
						: $urandom_range(1023));
				else if (pick < 96)
					add_op(OP_CLEAR, rand_key(), $urandom, $urandom);
				else
					add_op(2'd3, rand_key(), $urandom, $urandom);
			end
		end

		// Sampled at the falling edge so the driver's updates have settled.
		while (pending.size() > 0 || start || results_due.size() > 0)
			@(negedge clk);
		repeat (50) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#150000000;
		$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
design/dhti_pkg.sv
design/dhti_ctrl.sv
design/dhti_dp.sv
design/double_hash_table_insert_top.sv
tb/sv/tb_top.sv
